// ===== rtl/core/ohm_pkg.sv =====
package ohm_pkg;

   // Character codes
   localparam logic [7:0] BS_CHAR    = 8'h08;
   localparam logic [7:0] NL_CHAR    = 8'h0A;
   localparam logic [7:0] UL_CHAR    = 8'h5F;
   localparam logic [7:0] LT_CHAR    = 8'h3C;
   localparam logic [7:0] GT_CHAR    = 8'h3E;
   localparam logic [7:0] AMP_CHAR   = 8'h26;
   localparam logic [7:0] SEMI_CHAR  = 8'h3B;
   localparam logic [7:0] SLASH_CHAR = 8'h2F;
   localparam logic [7:0] B_CHAR     = 8'h62;
   localparam logic [7:0] U_CHAR     = 8'h75;
   localparam logic [7:0] L_CHAR     = 8'h6C;
   localparam logic [7:0] G_CHAR     = 8'h67;
   localparam logic [7:0] T_CHAR     = 8'h74;
   localparam logic [7:0] NUL_CHAR   = 8'h00;

   // Body of a command: what follows the tag segments
   localparam logic [2:0] BODY_CHAR = 3'd0;
   localparam logic [2:0] BODY_LT   = 3'd1;
   localparam logic [2:0] BODY_GT   = 3'd2;
   localparam logic [2:0] BODY_NL   = 3'd3;
   localparam logic [2:0] BODY_BARE = 3'd4;

   // Output segments in emission order
   localparam logic [2:0] SEG_CB   = 3'd0;
   localparam logic [2:0] SEG_CU   = 3'd1;
   localparam logic [2:0] SEG_OB   = 3'd2;
   localparam logic [2:0] SEG_OU   = 3'd3;
   localparam logic [2:0] SEG_BODY = 3'd4;

   // One decoded window step, handed from front to back
   typedef struct packed {
      logic       close_b;
      logic       close_u;
      logic       open_b;
      logic       open_u;
      logic [2:0] body;
      logic [7:0] ch;
      logic       run_last;
      logic       stream_end;
   } cmd_type;

   // Index of the last byte of a segment
   function automatic logic [1:0] seg_last_idx(input logic [2:0] seg, input logic [2:0] body);
      logic [1:0] last;
      last = 2'd0;
      unique case (seg)
         SEG_CB, SEG_CU: last = 2'd3;
         SEG_OB, SEG_OU: last = 2'd2;
         SEG_BODY: begin
            unique case (body)
               BODY_LT, BODY_GT: last = 2'd3;
               BODY_NL:          last = 2'd1;
               default:          last = 2'd0;
            endcase
         end
         default: last = 2'd0;
      endcase
      return last;
   endfunction

   // Byte at a position inside a segment
   function automatic logic [7:0] seg_byte(input logic [2:0] seg, input logic [1:0] idx,
                                           input logic [2:0] body, input logic [7:0] ch);
      logic [7:0] b;
      logic [7:0] letter;
      b = NUL_CHAR;
      letter = ((seg == SEG_CB) || (seg == SEG_OB)) ? B_CHAR : U_CHAR;
      unique case (seg)
         SEG_CB, SEG_CU: begin
            unique case (idx)
               2'd0:    b = LT_CHAR;
               2'd1:    b = SLASH_CHAR;
               2'd2:    b = letter;
               default: b = GT_CHAR;
            endcase
         end
         SEG_OB, SEG_OU: begin
            unique case (idx)
               2'd0:    b = LT_CHAR;
               2'd1:    b = letter;
               default: b = GT_CHAR;
            endcase
         end
         SEG_BODY: begin
            unique case (body)
               BODY_LT, BODY_GT: begin
                  unique case (idx)
                     2'd0:    b = AMP_CHAR;
                     2'd1:    b = (body == BODY_LT) ? L_CHAR : G_CHAR;
                     2'd2:    b = T_CHAR;
                     default: b = SEMI_CHAR;
                  endcase
               end
               BODY_NL:   b = NL_CHAR;
               BODY_CHAR: b = ch;
               default:   b = NUL_CHAR;
            endcase
         end
         default: b = NUL_CHAR;
      endcase
      return b;
   endfunction

endpackage

// ===== rtl/core/ohm_req_if.sv =====
interface ohm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== rtl/core/ohm_rsp_if.sv =====
interface ohm_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_valid;
   logic       run_last;
   logic       stream_end;

   modport source (output valid, output out_byte, output out_valid, output run_last,
                   output stream_end, input ready);
   modport sink (input valid, input out_byte, input out_valid, input run_last,
                 input stream_end, output ready);
endinterface

// ===== rtl/core/ohm_front.sv =====
module ohm_front import ohm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   ohm_req_if.sink req_chan,
   input  logic    q_full,
   output logic    q_push,
   output cmd_type q_cmd
);

   logic [7:0] win_ff [3];
   logic [7:0] win_in [3];
   logic [1:0] fill_ff, fill_in;
   logic       bold_ff, bold_in;
   logic       ul_ff, ul_in;
   logic       skip_ff, skip_in;
   logic       flush_ff, flush_in;

   logic [7:0] win_ins [3];
   logic [1:0] fill_ins;
   logic       accept, step, last_mode;
   logic [7:0] w0, w1, w2;
   logic [1:0] fw;
   logic       drop, nl_pair, has_bs, h_bold, h_ital;
   logic       n_bold, n_ul, n_skip;
   logic [1:0] k;
   logic [7:0] hch;
   logic [7:0] s0, s1;
   logic [1:0] fill_nx;
   logic       done;

   // Accept while not flushing and the queue has room
   assign req_chan.ready = !flush_ff && !q_full;

   always_comb begin
      accept = req_chan.valid && req_chan.ready;

      // Drop the new word into the first free window slot
      for (int j = 0; j < 3; j++) begin
         win_ins[j] = (fill_ff == 2'(j)) ? req_chan.in_byte : win_ff[j];
      end
      fill_ins = fill_ff + 2'd1;

      last_mode = flush_ff || req_chan.in_last;
      step = flush_ff ? !q_full : (accept && (req_chan.in_last || fill_ins == 2'd3));

      w0 = flush_ff ? win_ff[0] : win_ins[0];
      w1 = flush_ff ? win_ff[1] : win_ins[1];
      w2 = flush_ff ? win_ff[2] : win_ins[2];
      fw = flush_ff ? fill_ff : fill_ins;

      // Classify the window head
      drop    = skip_ff && (w0 == NL_CHAR);
      nl_pair = !drop && (w0 == NL_CHAR) && (w1 == NL_CHAR);
      has_bs  = (w1 == BS_CHAR);
      h_bold  = has_bs && (w0 == w2);
      h_ital  = has_bs && (w0 == UL_CHAR);
      if (h_bold && h_ital) begin
         if (ul_ff) begin
            h_bold = 1'b0;
         end else begin
            h_ital = 1'b0;
         end
      end
      hch = h_ital ? w2 : w0;

      if (drop) begin
         k = 2'd1;
         n_bold = bold_ff;
         n_ul = ul_ff;
         n_skip = 1'b1;
      end else if (nl_pair) begin
         k = 2'd2;
         n_bold = 1'b0;
         n_ul = 1'b0;
         n_skip = 1'b1;
      end else begin
         k = (h_bold || h_ital) ? 2'd3 : 2'd1;
         n_bold = h_bold;
         n_ul = h_ital;
         n_skip = 1'b0;
      end

      // Shift out consumed bytes, zeros come in behind
      case (k)
         2'd1:    begin s0 = w1;       s1 = w2;       end
         2'd2:    begin s0 = w2;       s1 = NUL_CHAR; end
         default: begin s0 = NUL_CHAR; s1 = NUL_CHAR; end
      endcase
      fill_nx = (fw > k) ? (fw - k) : 2'd0;

      // Stream is finished when nothing left would produce output
      done = (fill_nx == 2'd0)
          || (n_skip && (s0 == NL_CHAR) && ((fill_nx == 2'd1) || (s1 == NL_CHAR)));

      // Build the command
      q_cmd.close_b    = !drop && bold_ff && !n_bold;
      q_cmd.close_u    = !drop && ul_ff && !n_ul;
      q_cmd.open_b     = !drop && !nl_pair && h_bold && !bold_ff;
      q_cmd.open_u     = !drop && !nl_pair && h_ital && !ul_ff;
      q_cmd.ch         = drop ? NUL_CHAR : hch;
      q_cmd.run_last   = !last_mode || done;
      q_cmd.stream_end = last_mode && done;
      if (drop) begin
         q_cmd.body = BODY_BARE;
      end else if (nl_pair) begin
         q_cmd.body = BODY_NL;
      end else if (hch == LT_CHAR) begin
         q_cmd.body = BODY_LT;
      end else if (hch == GT_CHAR) begin
         q_cmd.body = BODY_GT;
      end else begin
         q_cmd.body = BODY_CHAR;
      end
      q_push = step && (!drop || (last_mode && done));

      // Next state
      win_in   = win_ff;
      fill_in  = fill_ff;
      bold_in  = bold_ff;
      ul_in    = ul_ff;
      skip_in  = skip_ff;
      flush_in = flush_ff;
      if (accept && !step) begin
         win_in  = win_ins;
         fill_in = fill_ins;
      end
      if (step) begin
         if (last_mode && done) begin
            for (int j = 0; j < 3; j++) begin
               win_in[j] = NUL_CHAR;
            end
            fill_in  = 2'd0;
            bold_in  = 1'b0;
            ul_in    = 1'b0;
            skip_in  = 1'b0;
            flush_in = 1'b0;
         end else begin
            win_in[0] = s0;
            win_in[1] = s1;
            win_in[2] = NUL_CHAR;
            fill_in   = fill_nx;
            bold_in   = n_bold;
            ul_in     = n_ul;
            skip_in   = n_skip;
            flush_in  = last_mode;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < 3; j++) begin
            win_ff[j] <= NUL_CHAR;
         end
         fill_ff  <= 2'd0;
         bold_ff  <= 1'b0;
         ul_ff    <= 1'b0;
         skip_ff  <= 1'b0;
         flush_ff <= 1'b0;
      end else begin
         win_ff   <= win_in;
         fill_ff  <= fill_in;
         bold_ff  <= bold_in;
         ul_ff    <= ul_in;
         skip_ff  <= skip_in;
         flush_ff <= flush_in;
      end
   end

endmodule

// ===== rtl/core/ohm_cmd_fifo.sv =====
module ohm_cmd_fifo import ohm_pkg::*; #(
   parameter int DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    empty,
   output cmd_type head_cmd
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in;
   logic [PTR_W-1:0]   rd_ff, rd_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   assign full     = (cnt_ff == CNT_W'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign head_cmd = slot_ff[rd_ff];

   // Advance pointers with wrap at the depth
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Hold the payload slots
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/core/ohm_back.sv =====
module ohm_back import ohm_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      q_empty,
   input  cmd_type   q_head,
   output logic      q_pop,
   ohm_rsp_if.source rsp_chan
);

   logic [3:0] done_ff, done_in;
   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       oval_ff, oval_in;
   logic       rlast_ff, rlast_in;
   logic       send_ff, send_in;

   logic [2:0] seg;
   logic       seg_end;
   logic       advance;

   assign rsp_chan.valid      = valid_ff;
   assign rsp_chan.out_byte   = byte_ff;
   assign rsp_chan.out_valid  = oval_ff;
   assign rsp_chan.run_last   = rlast_ff;
   assign rsp_chan.stream_end = send_ff;

   always_comb begin
      // Pick the first segment still owed
      if (q_head.close_b && !done_ff[0]) begin
         seg = SEG_CB;
      end else if (q_head.close_u && !done_ff[1]) begin
         seg = SEG_CU;
      end else if (q_head.open_b && !done_ff[2]) begin
         seg = SEG_OB;
      end else if (q_head.open_u && !done_ff[3]) begin
         seg = SEG_OU;
      end else begin
         seg = SEG_BODY;
      end
      seg_end = (idx_ff == seg_last_idx(seg, q_head.body));
      advance = !q_empty && (!valid_ff || rsp_chan.ready);
      q_pop   = advance && seg_end && (seg == SEG_BODY);

      done_in  = done_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff && !rsp_chan.ready;
      byte_in  = byte_ff;
      oval_in  = oval_ff;
      rlast_in = rlast_ff;
      send_in  = send_ff;

      // Emit one word and step through the segments
      if (advance) begin
         valid_in = 1'b1;
         byte_in  = seg_byte(seg, idx_ff, q_head.body, q_head.ch);
         oval_in  = (q_head.body != BODY_BARE);
         rlast_in = (seg == SEG_BODY) && seg_end && q_head.run_last;
         send_in  = (seg == SEG_BODY) && seg_end && q_head.stream_end;
         if (seg_end) begin
            idx_in = 2'd0;
            if (seg == SEG_BODY) begin
               done_in = 4'd0;
            end else begin
               done_in[seg[1:0]] = 1'b1;
            end
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff  <= 4'd0;
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         done_ff  <= done_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // Hold the output word payload
   always_ff @(posedge clock) begin
      byte_ff  <= byte_in;
      oval_ff  <= oval_in;
      rlast_ff <= rlast_in;
      send_ff  <= send_in;
   end

endmodule

// ===== rtl/core/overstrike_text_to_html_markup.sv =====
// The input word that completes a step is written into the command queue, and each output
// word is registered from the queue head. Throughput: one input word per cycle while the
// queue has room and no flush is under way; tags and entities drain at one word per cycle
// while the receiver is ready, from the command queue (QUEUE_DEPTH entries). After a final
// word the input side is held while the window flushes and while the queue is full. Reset is
// synchronous and clears the window, the open tags, the queue and the output valid flag.
module overstrike_text_to_html_markup import ohm_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic      clock,
   input  logic      reset,
   ohm_req_if.sink   req_chan,
   ohm_rsp_if.source rsp_chan
);

   logic    q_push, q_pop, q_full, q_empty;
   cmd_type q_cmd, q_head;

   ohm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_cmd    (q_cmd)
   );

   ohm_cmd_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .pop      (q_pop),
      .full     (q_full),
      .empty    (q_empty),
      .head_cmd (q_head)
   );

   ohm_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== rtl/core/ohm_checker.sv =====
module ohm_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] out_byte,
   input logic       out_valid,
   input logic       run_last,
   input logic       stream_end
);

   // Hold a stalled output word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_byte) && $stable(run_last))
      else $error("stalled output word changed");

   // End of stream closes the item's run
   a_end_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && stream_end |-> run_last)
      else $error("stream end without run end");

   // A bare marker is always the stream's last word and carries zero
   a_bare: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !out_valid |-> run_last && stream_end && (out_byte == 8'h00))
      else $error("malformed bare end marker");

   // Output is empty right after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid after reset");

endmodule

bind overstrike_text_to_html_markup ohm_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .out_byte   (rsp_chan.out_byte),
   .out_valid  (rsp_chan.out_valid),
   .run_last   (rsp_chan.run_last),
   .stream_end (rsp_chan.stream_end)
);

// ===== tb/overstrike_text_to_html_markup_tb.sv =====
module overstrike_text_to_html_markup_tb;
   import ohm_pkg::*;

   localparam int MAX_WORDS    = 20;
   localparam int TEXT_ITEMS   = 180;
   localparam int LONG_HOLD    = 150;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int PRINT_LIMIT  = 40;

   // One word of HTML text as it leaves the block
   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_valid;
      logic       run_last;
      logic       stream_end;
   } markup_word_type;

   // Tracks the converter state and the HTML words still owed by the block
   class markup_tracker;
      logic [7:0]      window [3];
      int unsigned     fill;
      bit              bold_open;
      bit              ul_open;
      bit              skipping;
      markup_word_type pending_html[$];
      markup_word_type step_html[$];
      int              mismatches;

      function new();
         clear_state();
         mismatches = 0;
      endfunction

      function void clear_state();
         for (int j = 0; j < 3; j++) window[j] = NUL_CHAR;
         fill = 0;
         bold_open = 0;
         ul_open = 0;
         skipping = 0;
      endfunction

      function void report_mismatch(string what, int got, int want);
         if (mismatches < PRINT_LIMIT)
            $display("%0t: %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
         mismatches++;
      endfunction

      // Queue one data byte, dropping anything past the per-word cap
      function void put_byte(logic [7:0] b);
         markup_word_type w;
         if (step_html.size() >= MAX_WORDS) return;
         w.out_byte = b;
         w.out_valid = 1'b1;
         w.run_last = 1'b0;
         w.stream_end = 1'b0;
         step_html.push_back(w);
      endfunction

      function void put_text(string s);
         for (int i = 0; i < s.len(); i++) put_byte(s[i]);
      endfunction

      // Advance the lookahead window by k bytes, filling with zero
      function void shift_window(int unsigned k);
         for (int j = 0; j < 3; j++) window[j] = (j + k < 3) ? window[j + k] : NUL_CHAR;
         fill = (fill > k) ? fill - k : 0;
      endfunction

      // Decode the head of the window
      function void step_head();
         logic [7:0] ch;
         logic [7:0] n1;
         logic [7:0] n2;
         bit         bold;
         bit         ital;
         ch = window[0];
         n1 = window[1];
         n2 = window[2];
         bold = 0;
         ital = 0;

         // drop newlines after a collapsed pair
         if (skipping) begin
            if (ch == NL_CHAR) begin
               shift_window(1);
               return;
            end
            skipping = 0;
         end

         // collapse a newline run, closing open tags
         if (ch == NL_CHAR && n1 == NL_CHAR) begin
            if (bold_open) begin
               put_text("</b>");
               bold_open = 0;
            end
            if (ul_open) begin
               put_text("</u>");
               ul_open = 0;
            end
            put_byte(NL_CHAR);
            put_byte(NL_CHAR);
            skipping = 1;
            shift_window(2);
            return;
         end

         // overstrike: underscore over underscore follows the open underline
         if (n1 == BS_CHAR) begin
            bold = (ch == n2);
            ital = (ch == UL_CHAR);
            if (bold && ital) begin
               if (ul_open) bold = 0;
               else ital = 0;
            end
         end

         if (bold_open && !bold) begin
            put_text("</b>");
            bold_open = 0;
         end
         if (ul_open && !ital) begin
            put_text("</u>");
            ul_open = 0;
         end
         if (bold && !bold_open) begin
            put_text("<b>");
            bold_open = 1;
         end
         if (ital) begin
            if (!ul_open) begin
               put_text("<u>");
               ul_open = 1;
            end
            ch = n2;
         end

         if (ch == LT_CHAR) put_text("&lt;");
         else if (ch == GT_CHAR) put_text("&gt;");
         else put_byte(ch);

         shift_window((bold || ital) ? 3 : 1);
      endfunction

      // Note an accepted text byte and queue the HTML words it causes
      function void take_text_byte(logic [7:0] b, logic last);
         markup_word_type w;
         step_html.delete();
         if (fill > 2) fill = 2;
         window[fill] = b;
         fill++;

         if (last) begin
            while (fill > 0) step_head();
            if (step_html.size() == 0) begin
               w = '0;
               step_html.push_back(w);
            end
            w = step_html.pop_back();
            w.stream_end = 1'b1;
            step_html.push_back(w);
            clear_state();
         end else if (fill == 3) begin
            step_head();
         end

         if (step_html.size() > 0) begin
            w = step_html.pop_back();
            w.run_last = 1'b1;
            step_html.push_back(w);
         end
         foreach (step_html[i]) pending_html.push_back(step_html[i]);
      endfunction

      // Compare one accepted HTML word with the oldest one owed
      function void check_html_word(markup_word_type got);
         markup_word_type want;
         if (pending_html.size() == 0) begin
            report_mismatch("unexpected word", int'(got), 0);
            return;
         end
         want = pending_html.pop_front();
         if (got.out_valid !== want.out_valid)
            report_mismatch("out_valid", int'(got.out_valid), int'(want.out_valid));
         if (got.out_byte !== want.out_byte)
            report_mismatch("out_byte", int'(got.out_byte), int'(want.out_byte));
         if (got.run_last !== want.run_last)
            report_mismatch("run_last", int'(got.run_last), int'(want.run_last));
         if (got.stream_end !== want.stream_end)
            report_mismatch("stream_end", int'(got.stream_end), int'(want.stream_end));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int unsigned cycle_count = 0;
   int          sent_items = 0;
   bit          send_steady = 0;
   bit          recv_steady = 0;
   bit          hold_off_request = 0;
   bit          holding_off = 0;

   markup_tracker tracker = new();

   ohm_req_if req_chan ();
   ohm_rsp_if rsp_chan ();

   overstrike_text_to_html_markup u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #5 clock = ~clock;

   // Mostly short gaps, a few long ones
   function automatic int idle_len(bit steady);
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   // Give up on a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Check every HTML word taken from the block
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         tracker.check_html_word({rsp_chan.out_byte, rsp_chan.out_valid,
                                  rsp_chan.run_last, rsp_chan.stream_end});
   end

   // Receiver: random stalls, a long hold-off on request
   initial begin
      rsp_chan.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_request) begin
            holding_off = 1;
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_off_request = 0;
            holding_off = 0;
         end else if (recv_steady || $urandom_range(0, 99) < 60) begin
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b0;
            repeat (idle_len(1'b0) + 1) @(posedge clock);
         end
      end
   end

   // Offer one text byte and hold it until accepted
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = idle_len(send_steady);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.in_byte <= b;
      req_chan.in_last <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      tracker.take_text_byte(b, last);
      sent_items++;
   endtask

   task automatic send_text(input string s, input bit ends);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], ends && (i == s.len() - 1));
   endtask

   // Stop offering and wait until every owed word has come
   task automatic wait_for_html_drain();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (tracker.pending_html.size() != 0);
   endtask

   // One stream built mostly from well-formed overstrike pieces
   task automatic send_random_stream(input int pieces);
      logic [7:0] text[$];
      logic [7:0] c;
      int         kind;
      for (int p = 0; p < pieces; p++) begin
         kind = $urandom_range(0, 99);
         c = 8'($urandom_range(0, 255));
         if (kind < 30) begin
            text.push_back(8'($urandom_range(32, 126)));
         end else if (kind < 45) begin
            text.push_back(c);
            text.push_back(BS_CHAR);
            text.push_back(c);
         end else if (kind < 58) begin
            text.push_back(UL_CHAR);
            text.push_back(BS_CHAR);
            text.push_back(c);
         end else if (kind < 64) begin
            text.push_back(UL_CHAR);
            text.push_back(BS_CHAR);
            text.push_back(UL_CHAR);
         end else if (kind < 74) begin
            repeat ($urandom_range(1, 4)) text.push_back(NL_CHAR);
         end else if (kind < 80) begin
            text.push_back($urandom_range(0, 1) ? LT_CHAR : GT_CHAR);
         end else if (kind < 88) begin
            // broken overstrike: mismatched pair or a lone backspace
            text.push_back(c);
            text.push_back(BS_CHAR);
            if ($urandom_range(0, 1)) text.push_back(c + 8'd1);
         end else begin
            text.push_back(c);
         end
      end
      foreach (text[i]) send_byte(text[i], i == text.size() - 1);
   endtask

   initial begin
      req_chan.valid   <= 1'b0;
      req_chan.in_byte <= NUL_CHAR;
      req_chan.in_last <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // bold, underline, underscore over underscore inside underline, entity at flush
      send_text("b\010b_\010u_\010_<", 1);
      // underscore over underscore opens bold, newline run closes it, then '>'
      send_text("_\010_\n\n\n>", 1);
      // newlines only: the final byte flushes nothing, giving a bare end marker
      send_text("\n\n\n\n\n", 1);
      // zero byte as data; the overstrike reaches past the end of the stream
      send_byte(NUL_CHAR, 1'b0);
      send_byte(BS_CHAR, 1'b1);
      send_byte(8'hFF, 1'b1);

      while (sent_items < 90) send_random_stream($urandom_range(3, 20));

      // Hold the receiver off while the sender keeps offering
      hold_off_request = 1;
      req_chan.valid <= 1'b0;
      wait (holding_off);
      @(posedge clock);
      send_steady = 1;
      send_random_stream(20);
      send_steady = 0;
      wait_for_html_drain();

      // A stretch without idling on either side
      send_steady = 1;
      recv_steady = 1;
      send_random_stream(12);
      send_steady = 0;
      recv_steady = 0;

      while (sent_items < TEXT_ITEMS) send_random_stream($urandom_range(3, 20));

      wait_for_html_drain();
      repeat (20) @(posedge clock);
      if (tracker.mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
